### design/swtm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-window throughput meter: shared definitions
// Window size, field widths, running-total widths and control structures.
// ----------------------------------------------------------------------------
`default_nettype none

package swtm_pkg;

    localparam int WINDOW         = 5;
    localparam int SAMPLE_BYTES_W = 31;
    localparam int SAMPLE_DUR_W   = 32;
    localparam int RATE_W         = 32;
    localparam int MS_SHIFT_W     = 10;

    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int BYTE_TOT_W = SAMPLE_BYTES_W + $clog2(WINDOW);
    localparam int DUR_TOT_W  = SAMPLE_DUR_W + $clog2(WINDOW);
    localparam int NUM_W      = BYTE_TOT_W + MS_SHIFT_W;
    localparam int PASS_W     = $clog2(DUR_TOT_W + 1);
    localparam int STEP_W     = $clog2(NUM_W + 1);

    typedef struct packed {
        logic start;
        logic replace;
    } t_acc_ctl;

endpackage

`default_nettype wire

### design/swtm_accum.sv
// ----------------------------------------------------------------------------
// Running-total accumulator
// Updates the byte and duration totals one bit per cycle, adding the new
// sample and, when the ring is full, subtracting the sample it replaces.
// ----------------------------------------------------------------------------
`default_nettype none

module swtm_accum (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire swtm_pkg::t_acc_ctl                    i_ctl,
    input  wire logic [swtm_pkg::SAMPLE_BYTES_W-1:0]   i_new_bytes,
    input  wire logic [swtm_pkg::SAMPLE_DUR_W-1:0]     i_new_dur,
    input  wire logic [swtm_pkg::SAMPLE_BYTES_W-1:0]   i_old_bytes,
    input  wire logic [swtm_pkg::SAMPLE_DUR_W-1:0]     i_old_dur,
    output logic                                       o_busy,
    output logic [swtm_pkg::BYTE_TOT_W-1:0]            o_byte_total,
    output logic [swtm_pkg::DUR_TOT_W-1:0]             o_dur_total
);
    import swtm_pkg::*;

    logic [BYTE_TOT_W-1:0]     r_bt;
    logic [DUR_TOT_W-1:0]      r_dt;
    logic [SAMPLE_BYTES_W-1:0] r_nb;
    logic [SAMPLE_DUR_W-1:0]   r_nd;
    logic [SAMPLE_BYTES_W-1:0] r_ob;
    logic [SAMPLE_DUR_W-1:0]   r_od;
    logic [1:0]                r_cb;
    logic [1:0]                r_cd;
    logic                      r_rep;
    logic [PASS_W-1:0]         r_cnt;
    logic                      r_busy;

    logic       w_sub_b;
    logic       w_sub_d;
    logic [2:0] w_sum_b;
    logic [2:0] w_sum_d;

    assign w_sub_b = r_rep & ~r_ob[0];
    assign w_sub_d = r_rep & ~r_od[0];
    assign w_sum_b = 3'(r_bt[0]) + 3'(r_nb[0]) + 3'(w_sub_b) + 3'(r_cb);
    assign w_sum_d = 3'(r_dt[0]) + 3'(r_nd[0]) + 3'(w_sub_d) + 3'(r_cd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bt   <= '0;
            r_dt   <= '0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_nb   <= i_new_bytes;
            r_nd   <= i_new_dur;
            r_ob   <= i_old_bytes;
            r_od   <= i_old_dur;
            r_rep  <= i_ctl.replace;
            r_cb   <= {1'b0, i_ctl.replace};
            r_cd   <= {1'b0, i_ctl.replace};
        end else if (r_busy) begin
            r_nb <= {1'b0, r_nb[SAMPLE_BYTES_W-1:1]};
            r_ob <= {1'b0, r_ob[SAMPLE_BYTES_W-1:1]};
            r_nd <= {1'b0, r_nd[SAMPLE_DUR_W-1:1]};
            r_od <= {1'b0, r_od[SAMPLE_DUR_W-1:1]};
            r_dt <= {w_sum_d[0], r_dt[DUR_TOT_W-1:1]};
            r_cd <= w_sum_d[2:1];
            if (r_cnt < PASS_W'(BYTE_TOT_W)) begin
                r_bt <= {w_sum_b[0], r_bt[BYTE_TOT_W-1:1]};
                r_cb <= w_sum_b[2:1];
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == PASS_W'(DUR_TOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_byte_total = r_bt;
    assign o_dur_total  = r_dt;

endmodule

`default_nettype wire

### design/swtm_div.sv
// ----------------------------------------------------------------------------
// Rate divider
// Scales the byte total by 1000 and divides it by the duration
// total, one quotient bit per cycle, saturating the rate at all-ones.
// ----------------------------------------------------------------------------
`default_nettype none

module swtm_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [swtm_pkg::BYTE_TOT_W-1:0]   i_byte_total,
    input  wire logic [swtm_pkg::DUR_TOT_W-1:0]    i_dur_total,
    output logic                                   o_busy,
    output logic [swtm_pkg::RATE_W-1:0]            o_rate
);
    import swtm_pkg::*;

    localparam logic [1:0] PH_MUL1 = 2'd0;
    localparam logic [1:0] PH_MUL2 = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic                  r_busy;
    logic [1:0]            r_phase;
    logic [BYTE_TOT_W-1:0] r_mul;
    logic [NUM_W-1:0]      r_num;
    logic [DUR_TOT_W-1:0]  r_den;
    logic [DUR_TOT_W-1:0]  r_rem;
    logic [RATE_W-1:0]     r_q;
    logic                  r_ovf;
    logic [STEP_W-1:0]     r_step;

    logic [DUR_TOT_W:0] w_trial;
    logic               w_ge;
    logic [DUR_TOT_W:0] w_diff;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_MUL1;
            r_step  <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= PH_MUL1;
            r_mul   <= i_byte_total;
            r_den   <= i_dur_total;
        end else if (r_busy) begin
            case (r_phase)
                PH_MUL1: begin
                    r_num   <= (NUM_W'(r_mul) << 10) - (NUM_W'(r_mul) << 4);
                    r_phase <= PH_MUL2;
                end
                PH_MUL2: begin
                    r_num   <= r_num - (NUM_W'(r_mul) << 3);
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_ovf   <= 1'b0;
                    r_step  <= '0;
                    r_phase <= PH_DIV;
                end
                PH_DIV: begin
                    r_num  <= {r_num[NUM_W-2:0], 1'b0};
                    r_rem  <= w_ge ? w_diff[DUR_TOT_W-1:0] : w_trial[DUR_TOT_W-1:0];
                    r_q    <= {r_q[RATE_W-2:0], w_ge};
                    r_ovf  <= r_ovf | r_q[RATE_W-1];
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_busy <= 1'b0;
                    end
                end
                default: begin
                    r_phase <= PH_MUL1;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_rate = r_ovf ? {RATE_W{1'b1}} : r_q;

endmodule

`default_nettype wire

### design/sliding_window_throughput_meter.sv
// ----------------------------------------------------------------------------
// Sliding-window throughput meter
// Holds the last WINDOW transfer samples and reports bytes per second.
//
// The slave stream takes one command per beat: tuser selects add (0) or
// query (1), tdata carries the sample byte count and duration in ms.
// Every beat yields exactly one result beat on the master stream: tdata
// is the rate, tuser carries has_samples and rate_valid.
// An add's result waits for the bit-serial update of the 34-bit byte and
// 35-bit duration running totals. A query's result waits for the 44-step
// quotient loop of the divider; a query with no samples goes straight to
// its result. One beat is worked on at a time and tready is high only
// while the block is idle.
// Reset empties the window and clears the totals; the sample store itself
// is not cleared. While the receiver stalls the finished result is held in
// the output register, and the next beat may be accepted and worked on
// until its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_throughput_meter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: sample_bytes[30:0], sample_duration[62:31], zero pad[63]
    input  wire logic [63:0] s_axis_tdata,
    // tuser: command
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: rate[31:0]
    output logic [31:0]      m_axis_tdata,
    // tuser: has_samples[0], rate_valid[1]
    output logic [1:0]       m_axis_tuser
);
    import swtm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam logic       CMD_ADD = 1'b0;
    localparam int         POS_W   = IDX_W + 2;

    logic [SAMPLE_BYTES_W-1:0] r_byte_store [WINDOW];
    logic [SAMPLE_DUR_W-1:0]   r_dur_store  [WINDOW];
    logic [SAMPLE_BYTES_W-1:0] r_old_bytes;
    logic [SAMPLE_DUR_W-1:0]   r_old_dur;
    logic [IDX_W-1:0]          r_oldest;
    logic [CNT_W-1:0]          r_fill;
    logic [1:0]                r_state;
    logic                      r_is_rate;
    logic                      r_out_valid;
    logic                      r_out_has;
    logic                      r_out_rv;
    logic [RATE_W-1:0]         r_out_rate;

    logic                      w_accept;
    logic                      w_cmd;
    logic [SAMPLE_BYTES_W-1:0] w_bytes;
    logic [SAMPLE_DUR_W-1:0]   w_dur;
    logic                      w_full;
    logic [POS_W-1:0]          w_pos;
    logic [IDX_W-1:0]          w_slot;
    logic                      w_out_free;
    logic                      w_out_load;
    logic                      w_div_start;
    t_acc_ctl                  w_acc_ctl;
    logic                      w_acc_busy;
    logic [BYTE_TOT_W-1:0]     w_byte_total;
    logic [DUR_TOT_W-1:0]      w_dur_total;
    logic                      w_div_busy;
    logic [RATE_W-1:0]         w_rate;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_cmd         = s_axis_tuser;
    assign w_bytes       = s_axis_tdata[SAMPLE_BYTES_W-1:0];
    assign w_dur         = s_axis_tdata[SAMPLE_BYTES_W+SAMPLE_DUR_W-1:SAMPLE_BYTES_W];
    assign w_full        = (r_fill == CNT_W'(WINDOW));
    assign w_pos         = POS_W'(r_oldest) + POS_W'(r_fill);
    assign w_slot        = w_full ? r_oldest :
                           (w_pos >= POS_W'(WINDOW)) ? IDX_W'(w_pos - POS_W'(WINDOW)) :
                           IDX_W'(w_pos);
    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign w_out_load    = (r_state == ST_DONE) & w_out_free;

    assign w_acc_ctl.start   = w_accept & (w_cmd == CMD_ADD);
    assign w_acc_ctl.replace = w_full;
    assign w_div_start       = w_accept & (w_cmd != CMD_ADD) & (r_fill != '0);

    swtm_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_acc_ctl),
        .i_new_bytes  (w_bytes),
        .i_new_dur    (w_dur),
        .i_old_bytes  (r_old_bytes),
        .i_old_dur    (r_old_dur),
        .o_busy       (w_acc_busy),
        .o_byte_total (w_byte_total),
        .o_dur_total  (w_dur_total)
    );

    swtm_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_div_start),
        .i_byte_total (w_byte_total),
        .i_dur_total  (w_dur_total),
        .o_busy       (w_div_busy),
        .o_rate       (w_rate)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc_ctl.start) begin
            r_byte_store[w_slot] <= w_bytes;
            r_dur_store[w_slot]  <= w_dur;
        end
        r_old_bytes <= r_byte_store[r_oldest];
        r_old_dur   <= r_dur_store[r_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_is_rate   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_is_rate <= w_div_start;
                        if (w_cmd == CMD_ADD) begin
                            r_state <= ST_ADD;
                            if (w_full) begin
                                r_oldest <= (r_oldest == IDX_W'(WINDOW - 1)) ? '0 :
                                            r_oldest + 1'b1;
                            end else begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end else if (w_div_start) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_ADD: begin
                    if (!w_acc_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_out_has   <= (r_fill != '0);
                        r_out_rv    <= r_is_rate;
                        r_out_rate  <= r_is_rate ? w_rate : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rate;
    assign m_axis_tuser  = {r_out_rv, r_out_has};

endmodule

`default_nettype wire
